// File: hdl/oatan_pkg.sv
// ----------------------------------------------------------------------------
// Octant atan2 approximation package
// Widths, angle constants, the pipeline stage record and the divider step
// shared by the angle core.
// ----------------------------------------------------------------------------
package oatan_pkg;

  // Field widths.
  localparam int COORD_W = 32;
  localparam int ANGLE_W = 13;

  // Quotient of smaller*512/larger lies in 0..512, so it needs ten bits,
  // one per divider stage.
  localparam int RAMP_SHIFT = 9;
  localparam int QUO_W      = RAMP_SHIFT + 1;
  localparam int DIV_STEPS  = QUO_W;

  // Base angles, 4096 is a full turn.
  localparam logic [ANGLE_W-1:0] ANG_ZERO     = 13'd0;
  localparam logic [ANGLE_W-1:0] ANG_QUARTER  = 13'd1024;
  localparam logic [ANGLE_W-1:0] ANG_HALF     = 13'd2048;
  localparam logic [ANGLE_W-1:0] ANG_3QUARTER = 13'd3072;
  localparam logic [ANGLE_W-1:0] ANG_FULL     = 13'd4096;

  // Payload carried through the divider stages.
  typedef struct packed {
    logic [COORD_W-1:0] rem;   // partial remainder, always below den after a step
    logic [COORD_W-1:0] den;   // larger magnitude, never zero
    logic [QUO_W-1:0]   quo;   // quotient bits developed so far
    logic [ANGLE_W-1:0] base;  // base angle of the octant
    logic               sub;   // subtract the ramp from the base when set
  } div_stage_t;

  // One restoring division step. The first step compares the numerator
  // itself (the weight-512 bit); later steps shift the remainder left first.
  function automatic div_stage_t div_step(div_stage_t s, logic first);
    logic [COORD_W:0] shifted;
    logic [COORD_W:0] diff;
    logic             ge;
    div_stage_t       r;
    shifted = first ? {1'b0, s.rem} : {s.rem, 1'b0};
    diff    = shifted - {1'b0, s.den};
    ge      = (shifted >= {1'b0, s.den});
    r       = s;
    r.rem   = ge ? diff[COORD_W-1:0] : shifted[COORD_W-1:0];
    r.quo   = {s.quo[QUO_W-2:0], ge};
    return r;
  endfunction

endpackage

// File: hdl/octant_atan2_approximation_core.sv
// ----------------------------------------------------------------------------
// Octant atan2 approximation core
// Pipelined approximate atan2 on signed 32-bit coordinates, 4096 = full turn.
// ----------------------------------------------------------------------------
// The core takes one (y, x) query per cycle while query_stall is low and returns
// the angles in query order. One stage forms the magnitudes, one compares them
// and picks the octant, ten stages of a restoring divider each develop one bit
// of the ramp smaller*512/larger, and one stage adds the ramp to or subtracts it
// from the octant's base angle. A zero x is taken as +1; a zero y gives 0, or
// 2048 for negative x. Results are in 0..4096, and 4096 can appear for positive
// x with y just below zero. A stall at the output holds every stage that has
// nowhere to go, while empty stages further up keep filling.
module octant_atan2_approximation_core
  import oatan_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      query_valid,
  output logic                      query_stall,
  input  logic signed [COORD_W-1:0] y_coord,
  input  logic signed [COORD_W-1:0] x_coord,
  output logic                      angle_valid,
  input  logic                      angle_stall,
  output logic        [ANGLE_W-1:0] angle
);

  // Stage one: magnitudes and sign flags.
  logic               s1_valid;
  logic [COORD_W-1:0] s1_ay;
  logic [COORD_W-1:0] s1_ax;
  logic               s1_yneg;
  logic               s1_xneg;
  logic               s1_yzero;

  // Stage two: octant chosen, divider operands set up.
  logic       s2_valid;
  div_stage_t s2_data;
  div_stage_t s2_next;

  // Divider stages.
  logic       dv_valid [DIV_STEPS];
  div_stage_t dv_data  [DIV_STEPS];

  // Ready of each stage: it may load when empty or when its content moves on.
  logic s1_ready;
  logic s2_ready;
  logic dv_ready [DIV_STEPS];
  logic out_ready;

  always_comb begin
    out_ready = !angle_valid || !angle_stall;
    dv_ready[DIV_STEPS-1] = !dv_valid[DIV_STEPS-1] || out_ready;
    for (int k = DIV_STEPS - 2; k >= 0; k--) begin
      dv_ready[k] = !dv_valid[k] || dv_ready[k+1];
    end
    s2_ready = !s2_valid || dv_ready[0];
    s1_ready = !s1_valid || s2_ready;
  end

  assign query_stall = !s1_ready;

  // Magnitudes; a zero x counts as +1, and the most negative value maps to 2^31.
  logic [COORD_W-1:0] ay_in;
  logic [COORD_W-1:0] ax_in;

  always_comb begin
    ay_in = y_coord[COORD_W-1] ? (~y_coord + 1'b1) : y_coord;
    if (x_coord == '0) begin
      ax_in = {{(COORD_W-1){1'b0}}, 1'b1};
    end else if (x_coord[COORD_W-1]) begin
      ax_in = ~x_coord + 1'b1;
    end else begin
      ax_in = x_coord;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= query_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && query_valid) begin
      s1_ay    <= ay_in;
      s1_ax    <= ax_in;
      s1_yneg  <= y_coord[COORD_W-1];
      s1_xneg  <= x_coord[COORD_W-1];
      s1_yzero <= (y_coord == '0);
    end
  end

  // Octant selection: the base angle, the ramp direction and which magnitude
  // is divided by which. Equal magnitudes give a ramp of 512 either way.
  logic ax_lt_ay;
  logic ay_lt_ax;

  always_comb begin
    ax_lt_ay = (s1_ax < s1_ay);
    ay_lt_ax = (s1_ay < s1_ax);
    s2_next  = '0;
    if (s1_yzero) begin
      // On the x axis the ramp is zero: divide zero by |x|.
      s2_next.rem  = '0;
      s2_next.den  = s1_ax;
      s2_next.base = s1_xneg ? ANG_HALF : ANG_ZERO;
      s2_next.sub  = 1'b0;
    end else begin
      unique case ({s1_xneg, s1_yneg})
        2'b00: begin
          if (ax_lt_ay) begin
            s2_next.base = ANG_QUARTER;
            s2_next.sub  = 1'b1;
          end else begin
            s2_next.base = ANG_ZERO;
            s2_next.sub  = 1'b0;
          end
        end
        2'b01: begin
          if (ay_lt_ax) begin
            s2_next.base = ANG_FULL;
            s2_next.sub  = 1'b1;
          end else begin
            s2_next.base = ANG_3QUARTER;
            s2_next.sub  = 1'b0;
          end
        end
        2'b10: begin
          if (ax_lt_ay) begin
            s2_next.base = ANG_QUARTER;
            s2_next.sub  = 1'b0;
          end else begin
            s2_next.base = ANG_HALF;
            s2_next.sub  = 1'b1;
          end
        end
        default: begin
          if (ay_lt_ax) begin
            s2_next.base = ANG_HALF;
            s2_next.sub  = 1'b0;
          end else begin
            s2_next.base = ANG_3QUARTER;
            s2_next.sub  = 1'b1;
          end
        end
      endcase
      // The smaller magnitude is divided by the larger one.
      s2_next.rem = ax_lt_ay ? s1_ax : s1_ay;
      s2_next.den = ax_lt_ay ? s1_ay : s1_ax;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_data <= s2_next;
    end
  end

  // Restoring divider, one quotient bit per stage, most significant first.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic       src_valid;
    div_stage_t src_data;

    if (k == 0) begin : g_first
      assign src_valid = s2_valid;
      assign src_data  = s2_data;
    end else begin : g_rest
      assign src_valid = dv_valid[k-1];
      assign src_data  = dv_data[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k] <= 1'b0;
      end else if (dv_ready[k]) begin
        dv_valid[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (dv_ready[k] && src_valid) begin
        dv_data[k] <= div_step(src_data, (k == 0));
      end
    end
  end

  // Output register: base angle plus or minus the ramp.
  div_stage_t         last;
  logic [ANGLE_W-1:0] ramp;
  logic [ANGLE_W-1:0] angle_next;

  always_comb begin
    last       = dv_data[DIV_STEPS-1];
    ramp       = {{(ANGLE_W-QUO_W){1'b0}}, last.quo};
    angle_next = last.sub ? (last.base - ramp) : (last.base + ramp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_valid <= 1'b0;
    end else if (out_ready) begin
      angle_valid <= dv_valid[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && dv_valid[DIV_STEPS-1]) begin
      angle <= angle_next;
    end
  end

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Octant atan2 approximation core testbench
// Sends (y, x) queries through the valid/stall input channel and checks
// every returned angle, in order, against an angle predicted in the bench.
// A directed set covers zero coordinates, the extreme values, equal
// magnitudes and every octant. Random queries follow, with random gaps on
// the input side in every other phase and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb_top;
  import oatan_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT    = 4000;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_ITEMS   = 100;
  localparam int SETTLE_CYCLES = 40;

  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;

  // One pending query with the idle cycles that precede it.
  typedef struct {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
    int unsigned               gap;
    bit                        drain;  // hold off until all angles are back
  } query_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      query_valid = 1'b0;
  logic                      query_stall;
  logic signed [COORD_W-1:0] y_coord = '0;
  logic signed [COORD_W-1:0] x_coord = '0;
  logic                      angle_valid;
  logic                      angle_stall = 1'b0;
  logic        [ANGLE_W-1:0] angle;

  query_t             pending_queries[$];
  logic [ANGLE_W-1:0] angles_due[$];

  int queries_sent    = 0;
  int angles_checked  = 0;
  int mismatch_count  = 0;
  int full_turn_seen  = 0;
  int stall_cycles    = 0;
  int drain_pauses    = 0;

  octant_atan2_approximation_core dut (
    .clk        (clk),
    .rst        (rst),
    .query_valid(query_valid),
    .query_stall(query_stall),
    .y_coord    (y_coord),
    .x_coord    (x_coord),
    .angle_valid(angle_valid),
    .angle_stall(angle_stall),
    .angle      (angle)
  );

  always #10 clk = ~clk;

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string msg);
    $display("tb: mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Linear ramp smaller*512/larger, truncating.
  function automatic longint unsigned octant_ramp(longint unsigned num,
                                                  longint unsigned den);
    return (num * 512) / den;
  endfunction

  // Expected angle for one query, worked out with 64-bit magnitudes.
  function automatic logic [ANGLE_W-1:0] predict_angle(logic signed [COORD_W-1:0] yc,
                                                       logic signed [COORD_W-1:0] xc);
    longint          sy;
    longint          sx;
    longint unsigned ay;
    longint unsigned ax;
    longint unsigned full;
    sy = yc;
    sx = xc;
    if (sx == 0) sx = 1;
    if (sy == 0) begin
      full = (sx < 0) ? ANG_HALF : ANG_ZERO;
    end else begin
      ax = (sx < 0) ? -sx : sx;
      ay = (sy < 0) ? -sy : sy;
      if (sx > 0) begin
        if (sy > 0) begin
          full = (ax < ay) ? ANG_QUARTER - octant_ramp(ax, ay) : octant_ramp(ay, ax);
        end else begin
          full = (ay < ax) ? ANG_FULL - octant_ramp(ay, ax)
                           : octant_ramp(ax, ay) + ANG_3QUARTER;
        end
      end else if (sy > 0) begin
        full = (ax < ay) ? octant_ramp(ax, ay) + ANG_QUARTER
                         : ANG_HALF - octant_ramp(ay, ax);
      end else begin
        full = (ay < ax) ? octant_ramp(ay, ax) + ANG_HALF
                         : ANG_3QUARTER - octant_ramp(ax, ay);
      end
    end
    return full[ANGLE_W-1:0];
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int unsigned pick_gap(bit gappy);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!gappy || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random coordinate weighted toward zero, extremes and small values.
  function automatic logic signed [COORD_W-1:0] pick_coord();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return '0;
    if (roll < 18) begin
      case ($urandom_range(0, 3))
        0: return C_MAX;
        1: return C_MIN;
        2: return -1;
        default: return 1;
      endcase
    end
    if (roll < 45) return $signed($urandom_range(0, 2000)) - 1000;
    return $urandom;
  endfunction

  task automatic add_query(input logic signed [COORD_W-1:0] yc,
                           input logic signed [COORD_W-1:0] xc,
                           input int unsigned gap, input bit drain);
    query_t q;
    q.y     = yc;
    q.x     = xc;
    q.gap   = gap;
    q.drain = drain;
    pending_queries.push_back(q);
  endtask

  // Input driver: records each transfer and presents the next query.
  int unsigned gap_left  = 0;
  bit          gap_armed = 1'b0;
  always @(posedge clk) begin
    query_t cur;
    bit     launch;
    if (rst) begin
      query_valid <= 1'b0;
      gap_armed = 1'b0;
    end else begin
      if (query_valid && !query_stall) begin
        angles_due.push_back(predict_angle(y_coord, x_coord));
        queries_sent++;
      end
      if (!(query_valid && query_stall)) begin
        launch = 1'b0;
        if (pending_queries.size() != 0) begin
          if (!gap_armed) begin
            gap_left  = pending_queries[0].gap;
            gap_armed = 1'b1;
            if (pending_queries[0].drain) drain_pauses++;
          end
          if (gap_left > 0) begin
            gap_left--;
          end else if (!pending_queries[0].drain || angles_due.size() == 0) begin
            cur       = pending_queries.pop_front();
            gap_armed = 1'b0;
            launch    = 1'b1;
            y_coord  <= cur.y;
            x_coord  <= cur.x;
          end
        end
        query_valid <= launch;
      end
    end
  end

  // Output monitor: checks each angle transfer and drives random stalls.
  int unsigned stall_left   = 0;
  int unsigned stall_window = 0;
  bit          stall_calm   = 1'b1;
  always @(posedge clk) begin
    logic [ANGLE_W-1:0] want;
    if (rst) begin
      angle_stall <= 1'b0;
    end else begin
      if (angle_valid && !angle_stall) begin
        if (angles_due.size() == 0) begin
          report_mismatch($sformatf("angle %0d with no query outstanding", angle));
        end else begin
          want = angles_due.pop_front();
          angles_checked++;
          if (want == ANG_FULL) full_turn_seen++;
          if (angle !== want)
            report_mismatch($sformatf("angle expected %0d got %0d", want, angle));
        end
      end
      // Switch between calm and stalling stretches now and then.
      stall_window++;
      if (stall_window == 150) begin
        stall_window = 0;
        stall_calm   = ($urandom_range(0, 2) == 0);
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (!stall_calm && $urandom_range(0, 99) < 25) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(1, 3);
      end
      if (stall_left > 0) stall_cycles++;
      angle_stall <= (stall_left > 0);
    end
  end

  // Watchdog on cycles without any transfer.
  int idle_count = 0;
  always @(posedge clk) begin
    if (rst || (query_valid && !query_stall) || (angle_valid && !angle_stall)) begin
      idle_count <= 0;
    end else if (idle_count >= IDLE_LIMIT) begin
      $display("tb: no transfer for %0d cycles", IDLE_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic signed [COORD_W-1:0] yr;
    logic signed [COORD_W-1:0] xr;
    bit                        gappy;
    int                        total_queries;

    // Zero coordinates: x zero acts as +1, y zero gives 0 or a half turn.
    add_query(0, 0, 0, 0);
    add_query(0, 5, 0, 0);
    add_query(0, -5, 0, 0);
    add_query(0, C_MIN, 0, 0);
    add_query(7, 0, 0, 0);
    add_query(-7, 0, 1, 0);
    // Extremes, including the most negative value.
    add_query(C_MAX, C_MAX, 0, 0);
    add_query(C_MAX, C_MIN, 0, 0);
    add_query(C_MIN, C_MAX, 0, 0);
    add_query(C_MIN, C_MIN, 0, 0);
    // Small negative y against large x: the full turn at positive x.
    add_query(-1, C_MAX, 0, 0);
    add_query(-1, C_MIN, 0, 0);
    add_query(-1, 1000, 2, 0);
    // Equal magnitudes in each quadrant.
    add_query(100, 100, 0, 0);
    add_query(100, -100, 0, 0);
    add_query(-100, 100, 0, 0);
    add_query(-100, -100, 0, 0);
    // One point in each octant.
    add_query(1, 3, 0, 0);
    add_query(3, 1, 0, 0);
    add_query(3, -1, 0, 0);
    add_query(1, -3, 0, 0);
    add_query(-1, -3, 0, 0);
    add_query(-3, -1, 0, 0);
    add_query(-3, 1, 0, 0);
    add_query(-1, 3, 0, 0);

    // Random phases; the third one starts only once the pipeline is empty.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      gappy = (p % 2 == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        yr = pick_coord();
        case ($urandom_range(0, 9))
          0: xr = ($urandom_range(0, 1) == 0) ? yr : -yr;
          1: xr = yr + $signed($urandom_range(0, 4)) - 2;
          default: xr = pick_coord();
        endcase
        add_query(yr, xr, pick_gap(gappy), (p == 2 && i == 0));
      end
    end
    total_queries = pending_queries.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Wait until every query has gone in and every angle has come back.
    while (queries_sent < total_queries || angles_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    foreach (angles_due[i])
      report_mismatch($sformatf("expected angle %0d never arrived", angles_due[i]));
    $display("tb: %0d queries, %0d angles checked, %0d full-turn results, %0d mismatches",
             queries_sent, angles_checked, full_turn_seen, mismatch_count);
    $display("tb: %0d output stall cycles, %0d drain pauses on the input side",
             stall_cycles, drain_pauses);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
